@@ design/bmdf_pkg.sv @@
// ---------------------------------------------------------------------------
// bmdf_pkg
// Shared types and codes for the broadcast mirror duplicate filter.
// ---------------------------------------------------------------------------
package bmdf_pkg;

    localparam int ID_W    = 32;
    localparam int NODE_W  = 32;
    localparam int TLEN_W  = 10;
    localparam int ULEN_W  = 8;
    localparam int CHAN_W  = 8;
    localparam int CNT_W   = 32;
    localparam int OP_W    = 3;
    localparam int DEC_W   = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_PREPARE  = 3'd0;
    localparam logic [OP_W-1:0] OP_EVALUATE = 3'd1;
    localparam logic [OP_W-1:0] OP_INJECTED = 3'd2;
    localparam logic [OP_W-1:0] OP_SUPPRESS = 3'd3;
    localparam logic [OP_W-1:0] OP_RST_CNT  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR_HIST = 3'd5;

    // decisions
    localparam logic [DEC_W-1:0] DEC_SEND          = 3'd0;
    localparam logic [DEC_W-1:0] DEC_NOT_ENABLED   = 3'd1;
    localparam logic [DEC_W-1:0] DEC_NOT_TEXT      = 3'd2;
    localparam logic [DEC_W-1:0] DEC_NOT_BROADCAST = 3'd3;
    localparam logic [DEC_W-1:0] DEC_NOT_LOCAL     = 3'd4;
    localparam logic [DEC_W-1:0] DEC_ALREADY       = 3'd5;
    localparam logic [DEC_W-1:0] DEC_EMPTY         = 3'd6;

    // settings the front end checks against
    typedef struct packed {
        logic              enable;
        logic              local_only;
        logic [NODE_W-1:0] local_node;
    } t_front_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DEC_W-1:0]  pre_dec;      // first failing static check, or send
        logic              need_search;  // history lookup required
        logic              empty;        // clipped payload is zero
        logic              trunc;
        logic [ULEN_W-1:0] plen;         // clipped usable length
        logic [ID_W-1:0]   id;
    } t_job;

endpackage

@@ design/bmdf_front.sv @@
// ---------------------------------------------------------------------------
// bmdf_front
// Accepts requests, clips the payload length and runs the static checks.
// ---------------------------------------------------------------------------
module bmdf_front #(
    parameter int MAX_PAYLOAD = 184
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bmdf_pkg::t_front_cfg        i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bmdf_pkg::OP_W-1:0]   i_opcode,
    input  logic                        i_is_text,
    input  logic                        i_is_broadcast,
    input  logic [bmdf_pkg::NODE_W-1:0] i_from_node,
    input  logic [bmdf_pkg::ID_W-1:0]   i_packet_id,
    input  logic [bmdf_pkg::TLEN_W-1:0] i_text_length,
    input  logic [bmdf_pkg::ULEN_W-1:0] i_usable_length,
    output logic                        o_job_valid,
    input  logic                        i_job_ready,
    output bmdf_pkg::t_job              o_job
);

    localparam logic [bmdf_pkg::ULEN_W-1:0] MAX_LEN = bmdf_pkg::ULEN_W'(MAX_PAYLOAD);

    logic                          r_valid;
    bmdf_pkg::t_job                r_job;
    bmdf_pkg::t_job                n_job;
    logic [bmdf_pkg::ULEN_W-1:0]   len_a;
    logic [bmdf_pkg::ULEN_W-1:0]   len_b;
    logic                          is_pkt;
    logic                          accept;

    assign o_in_ready  = !r_valid || i_job_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        // usable length never exceeds the text length or the payload limit
        len_a = ({2'b00, i_usable_length} > i_text_length) ?
                i_text_length[bmdf_pkg::ULEN_W-1:0] : i_usable_length;
        len_b = (len_a > MAX_LEN) ? MAX_LEN : len_a;

        is_pkt = (i_opcode == bmdf_pkg::OP_PREPARE) || (i_opcode == bmdf_pkg::OP_EVALUATE);

        n_job.op    = i_opcode;
        n_job.id    = i_packet_id;
        n_job.plen  = len_b;
        n_job.empty = (len_b == '0);
        n_job.trunc = ({2'b00, len_b} < i_text_length);

        if (!i_cfg.enable) begin
            n_job.pre_dec = bmdf_pkg::DEC_NOT_ENABLED;
        end else if (!i_is_text) begin
            n_job.pre_dec = bmdf_pkg::DEC_NOT_TEXT;
        end else if (!i_is_broadcast) begin
            n_job.pre_dec = bmdf_pkg::DEC_NOT_BROADCAST;
        end else if (i_cfg.local_only && (i_from_node != i_cfg.local_node)) begin
            n_job.pre_dec = bmdf_pkg::DEC_NOT_LOCAL;
        end else begin
            n_job.pre_dec = bmdf_pkg::DEC_SEND;
        end

        n_job.need_search = (is_pkt && (n_job.pre_dec == bmdf_pkg::DEC_SEND)) ||
                            (i_opcode == bmdf_pkg::OP_INJECTED) ||
                            (i_opcode == bmdf_pkg::OP_SUPPRESS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

@@ design/bmdf_queue.sv @@
// ---------------------------------------------------------------------------
// bmdf_queue
// Two-entry queue of classified requests between front and back.
// ---------------------------------------------------------------------------
module bmdf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bmdf_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bmdf_pkg::t_job o_pop_job
);

    bmdf_pkg::t_job r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_job    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

@@ design/bmdf_back.sv @@
// ---------------------------------------------------------------------------
// bmdf_back
// Searches the id history, updates history and counters, holds the result.
// ---------------------------------------------------------------------------
module bmdf_back #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bmdf_pkg::CHAN_W-1:0] i_out_channel,
    input  logic                        i_job_valid,
    output logic                        o_job_ready,
    input  bmdf_pkg::t_job              i_job,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [115:0]                o_res
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(HISTORY_DEPTH);
    localparam logic [bmdf_pkg::CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [bmdf_pkg::ID_W-1:0]  r_mem [HISTORY_DEPTH];
    logic [bmdf_pkg::ID_W-1:0]  r_rd_data;
    logic [1:0]                 r_state;
    bmdf_pkg::t_job             r_job;
    logic [FW-1:0]              r_issue;
    logic                       r_pend;
    logic                       r_hit;
    logic [AW-1:0]              r_next;
    logic [FW-1:0]              r_fill;
    logic [bmdf_pkg::CNT_W-1:0] r_mirrored;
    logic [bmdf_pkg::CNT_W-1:0] r_suppressed;
    logic [bmdf_pkg::CNT_W-1:0] r_injected;
    logic                       r_res_valid;
    logic [115:0]               r_res;

    logic                       issue;
    logic                       hit_now;
    logic                       slot_free;
    logic                       finish;
    logic [bmdf_pkg::DEC_W-1:0] n_dec;
    logic                       n_record;
    logic                       n_send;
    logic [bmdf_pkg::CNT_W-1:0] n_mirrored;
    logic [bmdf_pkg::CNT_W-1:0] n_suppressed;
    logic [bmdf_pkg::CNT_W-1:0] n_injected;
    logic [bmdf_pkg::ULEN_W-1:0] n_plen;
    logic                       n_trunc;
    logic [bmdf_pkg::CHAN_W-1:0] n_chan;

    assign o_job_ready = (r_state == ST_IDLE);
    assign issue       = (r_state == ST_SEARCH) && (r_issue < r_fill);
    assign hit_now     = r_pend && (r_rd_data == r_job.id);
    assign slot_free   = !r_res_valid || i_res_ready;
    assign finish      = (r_state == ST_FINISH) && slot_free;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_dec        = bmdf_pkg::DEC_SEND;
        n_record     = 1'b0;
        n_send       = 1'b0;
        n_mirrored   = r_mirrored;
        n_suppressed = r_suppressed;
        n_injected   = r_injected;
        case (r_job.op)
            bmdf_pkg::OP_PREPARE: begin
                if (r_job.pre_dec != bmdf_pkg::DEC_SEND) begin
                    n_dec = r_job.pre_dec;
                end else if (r_hit) begin
                    n_dec = bmdf_pkg::DEC_ALREADY;
                end else if (r_job.empty) begin
                    n_dec = bmdf_pkg::DEC_EMPTY;
                end
                if (n_dec == bmdf_pkg::DEC_SEND) begin
                    n_send     = 1'b1;
                    n_record   = 1'b1;
                    n_mirrored = (r_mirrored == CNT_MAX) ? r_mirrored : r_mirrored + 1'b1;
                end else begin
                    n_suppressed = (r_suppressed == CNT_MAX) ?
                                   r_suppressed : r_suppressed + 1'b1;
                end
            end
            bmdf_pkg::OP_EVALUATE: begin
                if (r_job.pre_dec != bmdf_pkg::DEC_SEND) begin
                    n_dec = r_job.pre_dec;
                end else if (r_hit) begin
                    n_dec = bmdf_pkg::DEC_ALREADY;
                end
            end
            bmdf_pkg::OP_INJECTED: begin
                n_record   = !r_hit;
                n_injected = (r_injected == CNT_MAX) ? r_injected : r_injected + 1'b1;
            end
            bmdf_pkg::OP_SUPPRESS: begin
                n_record = !r_hit;
            end
            bmdf_pkg::OP_RST_CNT: begin
                n_mirrored   = '0;
                n_suppressed = '0;
                n_injected   = '0;
            end
            default: begin
            end
        endcase
        n_plen  = n_send ? r_job.plen : '0;
        n_trunc = n_send && r_job.trunc;
        n_chan  = n_send ? i_out_channel : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend       <= 1'b0;
            r_hit        <= 1'b0;
            r_issue      <= '0;
            r_next       <= '0;
            r_fill       <= '0;
            r_mirrored   <= '0;
            r_suppressed <= '0;
            r_injected   <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready && !finish) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_hit   <= 1'b0;
                        r_state <= i_job.need_search ? ST_SEARCH : ST_FINISH;
                    end
                end
                ST_SEARCH: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (hit_now) begin
                        r_hit   <= 1'b1;
                        r_state <= ST_FINISH;
                    end else if (!issue && !r_pend) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (slot_free) begin
                        r_mirrored   <= n_mirrored;
                        r_suppressed <= n_suppressed;
                        r_injected   <= n_injected;
                        r_res_valid  <= 1'b1;
                        r_state      <= ST_IDLE;
                        if (r_job.op == bmdf_pkg::OP_CLR_HIST) begin
                            r_next <= '0;
                            r_fill <= '0;
                        end else if (n_record) begin
                            r_next <= (r_next == LAST_ADDR) ? '0 : r_next + 1'b1;
                            if (r_fill < FULL_FILL) begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // job register, history memory read and write, result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_job_valid) begin
            r_job <= i_job;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_issue[AW-1:0]];
        end
        if (finish && n_record && (r_job.op != bmdf_pkg::OP_CLR_HIST)) begin
            r_mem[r_next] <= r_job.id;
        end
        if (finish) begin
            r_res <= {n_injected, n_suppressed, n_mirrored, n_chan, n_trunc, n_plen, n_dec};
        end
    end

endmodule

@@ design/broadcast_mirror_dedup_filter.sv @@
// ---------------------------------------------------------------------------
// broadcast_mirror_dedup_filter
// Decides whether received packets are mirrored and filters repeated ids.
// ---------------------------------------------------------------------------
// One result per request, in request order. A request with a history lookup
// (prepare or evaluate that passes the static checks, note injected,
// suppress id) scans the filled part of the id history, which sits in a
// single-port memory that is read one entry per cycle; the lookup stops
// early on a match. Other requests skip the search in the back end. A front
// register and a two-entry queue keep accepting requests while the back end
// searches, and an output register holds the finished result until it is
// taken. The history needs no clearing pass: only entries below the fill
// count are searched.
// Configuration writes are always ready and must only be issued when no
// request is in flight.
// ---------------------------------------------------------------------------
module broadcast_mirror_dedup_filter #(
    parameter int HISTORY_DEPTH = 32,   // ids kept in the ring history, 1..256
    parameter int MAX_PAYLOAD   = 184   // payload byte limit, 1..255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,

    // configuration write: 0 mirror_enable, 1 local_only, 2 local_node,
    // 3 out_channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,

    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,  // from_node[31:0], packet_id[63:32],
                                        // text_length[73:64], usable_length[81:74]
    input  logic [4:0]   s_axis_tuser,  // opcode[2:0], is_text[3], is_broadcast[4]

    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata   // decision[2:0], payload_length[10:3],
                                        // truncated[11], channel[19:12],
                                        // mirrored_count[51:20],
                                        // suppressed_count[83:52],
                                        // injected_count[115:84]
);

    localparam logic [1:0] CFG_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_LOCAL_ONLY = 2'd1;
    localparam logic [1:0] CFG_LOCAL_NODE = 2'd2;
    localparam logic [1:0] CFG_CHANNEL    = 2'd3;

    logic                        r_enable;
    logic                        r_local_only;
    logic [bmdf_pkg::NODE_W-1:0] r_local_node;
    logic [bmdf_pkg::CHAN_W-1:0] r_out_channel;

    bmdf_pkg::t_front_cfg front_cfg;
    bmdf_pkg::t_job       fq_job;
    bmdf_pkg::t_job       qb_job;
    logic                 fq_valid;
    logic                 fq_ready;
    logic                 qb_valid;
    logic                 qb_ready;
    logic [115:0]         res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_local_only  <= 1'b0;
            r_local_node  <= '0;
            r_out_channel <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:     r_enable      <= i_cfg_data[0];
                CFG_LOCAL_ONLY: r_local_only  <= i_cfg_data[0];
                CFG_LOCAL_NODE: r_local_node  <= i_cfg_data;
                CFG_CHANNEL:    r_out_channel <= i_cfg_data[bmdf_pkg::CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign front_cfg.enable     = r_enable;
    assign front_cfg.local_only = r_local_only;
    assign front_cfg.local_node = r_local_node;

    // front: clip length, static checks
    bmdf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (front_cfg),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_opcode        (s_axis_tuser[2:0]),
        .i_is_text       (s_axis_tuser[3]),
        .i_is_broadcast  (s_axis_tuser[4]),
        .i_from_node     (s_axis_tdata[31:0]),
        .i_packet_id     (s_axis_tdata[63:32]),
        .i_text_length   (s_axis_tdata[73:64]),
        .i_usable_length (s_axis_tdata[81:74]),
        .o_job_valid     (fq_valid),
        .i_job_ready     (fq_ready),
        .o_job           (fq_job)
    );

    bmdf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_job   (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_job    (qb_job)
    );

    // back: history search, history and counter update, result register
    bmdf_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_out_channel (r_out_channel),
        .i_job_valid   (qb_valid),
        .o_job_ready   (qb_ready),
        .i_job         (qb_job),
        .o_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .o_res         (res)
    );

    assign m_axis_tdata = {4'b0000, res};

endmodule
